// ----- design/sgb_pkg.sv -----
// Shared types and constants for the grid broadphase.
package sgb_pkg;
  localparam int GridDimDefault = 32;
  localparam int MaxObjectsDefault = 64;
  localparam logic [15:0] CellSizeReset = 16'd64;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  obj_id;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0] rect_w;
    logic [14:0] rect_h;
  } req_t;

  typedef struct packed {
    logic [5:0] found_id;
    logic       hit;
    logic       last;
    logic       clipped;
  } res_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [5:0] obj_id;
    logic       in_grid;
    logic       clip;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [7:0] y0;
    logic [7:0] y1;
  } cmd_t;
endpackage

// ----- design/sgb_if.sv -----
// Valid/ready channel interfaces.
interface sgb_req_if import sgb_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sgb_res_if import sgb_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/sgb_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
module sgb_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/sgb_front.sv -----
// Front end: floor division of coordinates into clipped cell spans.
module sgb_front import sgb_pkg::*; #(
  parameter int GridDim = GridDimDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] cell_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  // four restoring dividers run in parallel, one quotient bit per cycle
  localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_OUT = 2'd2;
  logic [1:0]  state;
  logic [4:0]  cnt;
  req_t        r;
  logic [15:0] d;
  logic [16:0] num [4];
  logic [16:0] rem [4];
  logic [16:0] quo [4];
  logic        neg [4];
  logic signed [17:0] av [4];

  always_comb begin
    av[0] = 18'(r.rect_x);
    av[1] = 18'(r.rect_x) + 18'($signed({1'b0, r.rect_w}));
    av[2] = 18'(r.rect_y);
    av[3] = 18'(r.rect_y) + 18'($signed({1'b0, r.rect_h}));
  end

  function automatic logic signed [18:0] fq(logic [16:0] q, logic [16:0] rm, logic n);
    logic signed [18:0] v;
    v = {2'b00, q};
    if (n) begin
      v = -v;
      if (rm != '0) v = v - 19'sd1;
    end
    return v;
  endfunction

  logic signed [18:0] lo_x, hi_x, lo_y, hi_y;
  logic clip_c, in_c;
  always_comb begin
    lo_x = fq(quo[0], rem[0], neg[0]);
    hi_x = fq(quo[1], rem[1], neg[1]);
    lo_y = fq(quo[2], rem[2], neg[2]);
    hi_y = fq(quo[3], rem[3], neg[3]);
    clip_c = lo_x < 0 || lo_y < 0 || hi_x > 19'(GridDim - 1) ||
             hi_y > 19'(GridDim - 1);
    if (lo_x < 0) lo_x = '0;
    if (lo_y < 0) lo_y = '0;
    if (hi_x > 19'(GridDim - 1)) hi_x = 19'(GridDim - 1);
    if (hi_y > 19'(GridDim - 1)) hi_y = 19'(GridDim - 1);
    in_c = lo_x <= hi_x && lo_y <= hi_y;
  end

  assign in_ready = state == S_IDLE;
  assign cmd_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          r <= in_data;
          d <= (cell_size == '0) ? 16'd1 : cell_size;
          state <= (in_data.req_type == REQ_INSERT || in_data.req_type == REQ_QUERY)
                   ? S_DIV : S_OUT;
          cnt <= 5'd0;
          for (int i = 0; i < 4; i++) begin
            rem[i] <= '0;
            quo[i] <= '0;
          end
        end
        S_DIV: begin
          for (int i = 0; i < 4; i++) begin
            logic [16:0] nv, tr;
            nv = (cnt == 5'd0) ? (av[i] < 0 ? 17'(-av[i]) : 17'(av[i])) : num[i];
            tr = {rem[i][15:0], nv[16]};
            if (cnt == 5'd0) neg[i] <= av[i] < 0;
            if (tr >= {1'b0, d}) begin
              rem[i] <= tr - {1'b0, d};
              quo[i] <= {quo[i][15:0], 1'b1};
            end else begin
              rem[i] <= tr;
              quo[i] <= {quo[i][15:0], 1'b0};
            end
            num[i] <= {nv[15:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) state <= S_OUT;
        end
        S_OUT: if (cmd_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.op = r.req_type;
    cmd.obj_id = r.obj_id;
    cmd.in_grid = in_c;
    cmd.clip = (r.req_type == REQ_INSERT || r.req_type == REQ_QUERY) ? clip_c : 1'b0;
    cmd.x0 = 8'(lo_x);
    cmd.x1 = 8'(hi_x);
    cmd.y0 = 8'(lo_y);
    cmd.y1 = 8'(hi_y);
  end
endmodule

// ----- design/sgb_queue.sv -----
// Two-entry command queue between front and back.
module sgb_queue import sgb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_data
);
  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] count;
  assign in_ready = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data = q[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        q[wp] <= in_data;
        wp <= ~wp;
      end
      if (out_valid && out_ready) rp <= ~rp;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end
endmodule

// ----- design/sgb_back.sv -----
// Back end: cell walk over the grid memory, clear sweep and result emission.
module sgb_back import sgb_pkg::*; #(
  parameter int GridDim = GridDimDefault,
  parameter int MaxObjects = MaxObjectsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res,
  output logic busy
);
  localparam int CW = $clog2(GridDim);
  localparam int AW = 2 * CW;
  localparam int Depth = 1 << AW;
  localparam logic [2:0] S_SWEEP = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_WAIT = 3'd3,
                         S_WR = 3'd4, S_SCAN = 3'd5, S_DONE = 3'd6;
  logic [2:0]    state;
  cmd_t          c;
  logic [CW-1:0] cx, cy;
  logic [AW-1:0] sweep;
  logic [63:0]   acc;
  logic [5:0]    sid;
  logic          found;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic          last_cell;

  sgb_ram #(.Width(64), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = {cx, cy};
  assign last_cell = cx == c.x1[CW-1:0] && cy == c.y1[CW-1:0];
  assign cmd_ready = state == S_IDLE && !res_valid;
  assign busy = state != S_IDLE || res_valid;

  always_comb begin
    we = 1'b0;
    waddr = {cx, cy};
    wdata = rdata | (64'd1 << c.obj_id);
    if (state == S_SWEEP) begin
      we = 1'b1;
      waddr = sweep;
      wdata = '0;
    end else if (state == S_WR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_SCAN) res_valid <= 1'b0;
      if (cfg_we) begin
        state <= S_SWEEP;
        sweep <= '0;
      end else begin
        case (state)
          S_SWEEP: begin
            sweep <= sweep + AW'(1);
            if (sweep == AW'(Depth - 1)) state <= S_IDLE;
          end
          S_IDLE: if (cmd_valid && !res_valid) begin
            c <= cmd;
            cx <= cmd.x0[CW-1:0];
            cy <= cmd.y0[CW-1:0];
            acc <= '0;
            sid <= '0;
            found <= 1'b0;
            if (cmd.op == REQ_CLEAR) begin
              sweep <= '0;
              state <= S_SWEEP;
              res <= '{found_id: 6'd0, hit: 1'b0, last: 1'b1, clipped: 1'b0};
              res_valid <= 1'b1;
            end else if ((cmd.op == REQ_INSERT && cmd.in_grid &&
                          32'(cmd.obj_id) < MaxObjects) ||
                         (cmd.op == REQ_QUERY && cmd.in_grid)) begin
              state <= S_RD;
            end else if (cmd.op == REQ_QUERY) begin
              state <= S_SCAN;
            end else begin
              res <= '{found_id: 6'd0, hit: 1'b0, last: 1'b1, clipped: cmd.clip};
              res_valid <= 1'b1;
            end
          end
          S_RD: state <= S_WAIT;
          S_WAIT: begin
            if (c.op == REQ_INSERT) begin
              state <= S_WR;
            end else begin
              acc <= acc | rdata;
              if (last_cell) state <= S_SCAN;
              else state <= S_RD;
              if (cy == c.y1[CW-1:0]) begin
                cy <= c.y0[CW-1:0];
                cx <= cx + CW'(1);
              end else begin
                cy <= cy + CW'(1);
              end
            end
          end
          S_WR: begin
            if (last_cell) begin
              res <= '{found_id: 6'd0, hit: 1'b0, last: 1'b1, clipped: c.clip};
              res_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_RD;
            end
            if (cy == c.y1[CW-1:0]) begin
              cy <= c.y0[CW-1:0];
              cx <= cx + CW'(1);
            end else begin
              cy <= cy + CW'(1);
            end
          end
          S_SCAN: if (!res_valid || res_ready) begin
            // one id per cycle unless res stalls; last if no higher bit left
            if (acc[sid] && 32'(sid) < MaxObjects) begin
              res <= '{found_id: sid, hit: 1'b1,
                       last: (acc >> sid) == 64'd1 || 32'(sid) == MaxObjects - 1,
                       clipped: c.clip};
              res_valid <= 1'b1;
              found <= 1'b1;
              if ((acc >> sid) == 64'd1 || 32'(sid) == MaxObjects - 1) state <= S_IDLE;
            end else if (sid == 6'd63 || 32'(sid) == MaxObjects - 1) begin
              if (!found) begin
                res <= '{found_id: 6'd0, hit: 1'b0, last: 1'b1, clipped: c.clip};
              end
              res_valid <= !found;
              state <= S_IDLE;
            end else begin
              res_valid <= 1'b0;
            end
            sid <= sid + 6'd1;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end
endmodule

// ----- design/spatial_grid_broadphase.sv -----
// Top level of the uniform grid broadphase.
// A request is divided serially in the front end and buffered in the two-entry queue;
// the back end then reads each covered cell on a query, or reads and writes it on an
// insert. One request per walk; a query scans one id per cycle (up to 64) unless stalled.
// A clear holds the back end while it sweeps every grid word (1024 on a 32 by 32 grid).
// Reset (synchronous, rst high) sets cell_size to 64 and runs that pass; so does a write.
module spatial_grid_broadphase import sgb_pkg::*; #(
  parameter int GRID_DIM = GridDimDefault,
  parameter int MAX_OBJECTS = MaxObjectsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  sgb_req_if.sink     req,
  sgb_res_if.source   res
);
  logic [15:0] cell_size;
  logic        f_valid, f_ready, q_valid, q_ready, busy;
  cmd_t        f_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (rst) cell_size <= CellSizeReset;
    else if (cfg_we) cell_size <= cfg_wdata;
  end

  sgb_front #(.GridDim(GRID_DIM)) u_front (
    .clk, .rst, .cell_size, .in_valid(req.valid), .in_ready(req.ready),
    .in_data(req.data), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );
  sgb_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cmd)
  );
  sgb_back #(.GridDim(GRID_DIM), .MaxObjects(MAX_OBJECTS)) u_back (
    .clk, .rst, .cfg_we, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(res.valid), .res_ready(res.ready), .res(res.data), .busy
  );

  a_hit_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.data.hit |-> res.data.last) else $error("miss not last");
  a_miss_id: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.data.hit |-> res.data.found_id == 6'd0) else $error("miss id");
  a_q_take: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> !busy) else $error("back took cmd while busy");
endmodule

// ----- sim/sgb_tb_if.sv -----
// Idle mode type shared by the testbench.
package sgb_tb_types;
  import sgb_pkg::*;
  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_mode_t;
endpackage

// ----- sim/testbench.sv -----
// Testbench for spatial_grid_broadphase: random and directed requests with a scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sgb_pkg::*;
  import sgb_tb_types::*;

  localparam int Dim = 32;
  localparam int WatchLimit = 400000;

  class grid_scoreboard;
    logic [63:0] cells [Dim*Dim];
    logic [15:0] size_reg;
    res_t pending[$];
    int errors;

    function void wipe();
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function int fdiv(int a, int d);
      int q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q = q - 1;
      return q;
    endfunction

    function void note_request(req_t r);
      int d, x0, x1, y0, y1, n;
      bit clip, ok;
      logic [63:0] acc;
      res_t e;
      d = (size_reg == 0) ? 1 : int'(size_reg);
      clip = 0;
      e = '0;
      e.last = 1;
      if (r.req_type == REQ_CLEAR) begin
        wipe();
        pending = {pending, e};
        return;
      end
      if (r.req_type != REQ_INSERT && r.req_type != REQ_QUERY) begin
        pending = {pending, e};
        return;
      end
      x0 = fdiv(int'(r.rect_x), d);
      x1 = fdiv(int'(r.rect_x) + int'(r.rect_w), d);
      y0 = fdiv(int'(r.rect_y), d);
      y1 = fdiv(int'(r.rect_y) + int'(r.rect_h), d);
      if (x0 < 0) begin x0 = 0; clip = 1; end
      if (x1 > Dim-1) begin x1 = Dim-1; clip = 1; end
      if (y0 < 0) begin y0 = 0; clip = 1; end
      if (y1 > Dim-1) begin y1 = Dim-1; clip = 1; end
      ok = (x0 <= x1) && (y0 <= y1);
      acc = '0;
      for (int cx = x0; ok && cx <= x1; cx++)
        for (int cy = y0; cy <= y1; cy++)
          if (r.req_type == REQ_INSERT) cells[cx*Dim+cy][r.obj_id] = 1'b1;
          else acc |= cells[cx*Dim+cy];
      e.clipped = clip;
      if (r.req_type == REQ_INSERT || acc == 0) begin
        pending = {pending, e};
        return;
      end
      n = $countones(acc);
      for (int i = 0; i < 64; i++)
        if (acc[i]) begin
          n--;
          e.found_id = i[5:0];
          e.hit = 1;
          e.last = (n == 0);
          pending = {pending, e};
        end
    endfunction

    task report_bad(string msg);
      errors++;
      if (errors <= 50) $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        report_bad($sformatf("unexpected word %p", got));
        return;
      end
      e = pending.pop_front();
      if (got.found_id !== e.found_id)
        report_bad($sformatf("found_id %0d exp %0d", got.found_id, e.found_id));
      if (got.hit !== e.hit)
        report_bad($sformatf("hit %b exp %b", got.hit, e.hit));
      if (got.last !== e.last)
        report_bad($sformatf("last %b exp %b", got.last, e.last));
      if (got.clipped !== e.clipped)
        report_bad($sformatf("clipped %b exp %b", got.clipped, e.clipped));
    endtask
  endclass

  logic clk, rst, cfg_we;
  logic [15:0] cfg_wdata;
  sgb_req_if req (clk);
  sgb_res_if res (clk);
  grid_scoreboard sb;
  idle_mode_t mode;
  int idle_cycles;

  spatial_grid_broadphase uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .res(res)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1; cfg_we = 0; cfg_wdata = '0;
    req.valid = 0; req.data = '0; res.ready = 0;
    sb = new();
    sb.size_reg = CellSizeReset;
    sb.wipe();
    mode = PH_NONE;
    repeat (8) @(posedge clk);
    rst <= 0;
  end

  // receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) sb.check_result(res.data);
      res.ready <= !((mode == PH_RECV || mode == PH_BOTH) &&
                     $urandom_range(99) < ((mode == PH_BOTH) ? 23 : 62));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(req_t r);
    while ((mode == PH_SEND || mode == PH_BOTH) &&
           $urandom_range(99) < ((mode == PH_BOTH) ? 23 : 62)) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.data <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_size(logic [15:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.size_reg = v;
    sb.wipe();
    repeat (1200) @(posedge clk);
  endtask

  function automatic req_t mk(logic [1:0] t, logic [5:0] id, int x, int y, int w, int h);
    req_t r;
    r.req_type = t; r.obj_id = id;
    r.rect_x = x[15:0]; r.rect_y = y[15:0];
    r.rect_w = w[14:0]; r.rect_h = h[14:0];
    return r;
  endfunction

  function automatic req_t rand_req(int sz);
    req_t r;
    int span, u;
    span = sz * Dim;
    u = $urandom_range(99);
    r = '0;
    r.req_type = (u < 45) ? REQ_INSERT : (u < 90) ? REQ_QUERY :
                 (u < 96) ? REQ_CLEAR : REQ_NONE;
    r.obj_id = 6'($urandom);
    if ($urandom_range(9) == 0) begin
      r.rect_x = 16'($urandom); r.rect_y = 16'($urandom);
      r.rect_w = 15'($urandom); r.rect_h = 15'($urandom);
    end else begin
      r.rect_x = 16'($urandom_range(span + sz) - sz);
      r.rect_y = 16'($urandom_range(span + sz) - sz);
      r.rect_w = 15'($urandom_range(sz * 3));
      r.rect_h = 15'($urandom_range(sz * 3));
    end
    return r;
  endfunction

  initial begin
    int sizes [4];
    sizes = '{64, 1, 65535, 7};
    @(negedge rst);
    @(posedge clk);
    repeat (1200) @(posedge clk);
    // directed
    send_word(mk(REQ_QUERY, 0, 0, 0, 0, 0));
    send_word(mk(REQ_INSERT, 0, 0, 0, 0, 0));
    send_word(mk(REQ_INSERT, 63, 2047, 2047, 0, 0));
    send_word(mk(REQ_INSERT, 21, -32768, -32768, 32767, 32767));
    send_word(mk(REQ_INSERT, 42, 32767, 32767, 32767, 32767));
    send_word(mk(REQ_QUERY, 5, -32768, -32768, 32767, 32767));
    send_word(mk(REQ_QUERY, 0, 0, 0, 63, 63));
    send_word(mk(REQ_QUERY, 0, -1, -1, 0, 0));
    send_word(mk(REQ_NONE, 63, -1, -1, 32767, 32767));
    send_word(mk(REQ_QUERY, 0, 0, 0, 2047, 2047));
    send_word(mk(REQ_CLEAR, 0, 0, 0, 0, 0));
    send_word(mk(REQ_QUERY, 0, 0, 0, 2047, 2047));
    drain();
    for (int i = 0; i < 64; i++) send_word(mk(REQ_INSERT, i, 100, 100, 0, 0));
    send_word(mk(REQ_QUERY, 0, 64, 64, 64, 64));
    // random phases over several cell sizes
    for (int p = 0; p < 4; p++) begin
      write_size(16'(sizes[p]));
      for (int m = 0; m < 4; m++) begin
        mode = idle_mode_t'(m);
        for (int k = 0; k < 22; k++) send_word(rand_req(sizes[p] > 2048 ? 2048 : sizes[p]));
        if (m == 1) drain();
      end
    end
    write_size(16'd0);
    mode = PH_BOTH;
    for (int k = 0; k < 30; k++) send_word(rand_req(1));
    mode = PH_NONE;
    drain();
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
